FILE: src/c2s_pkg.sv
package c2s_pkg;

    // Word widths of ports and datapaths.
    localparam int COORD_BITS   = 24;
    localparam int CORDIC_STEPS = 20;
    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 20;
    localparam int ACC_BITS     = 32;

    // Micro-rotation count, capped at arctangent table length.
    localparam int NSTEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int ROOT_BITS = COORD_BITS + FRAC_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int CW        = ROOT_BITS + 4;

    // Clock edges from request acceptance to result strobe.
    localparam int LATENCY = ROOT_BITS + NSTEPS + 4;

    // atan(2^-i) as 32-bit binary angles, 2^31 standing for pi.
    localparam logic [ACC_BITS-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

FILE: src/c2s_isqrt.sv
module c2s_isqrt (
    input  logic                            clk,
    input  logic [c2s_pkg::SQ_BITS-1:0]     radicand,
    output logic [c2s_pkg::ROOT_BITS-1:0]   root
);
    import c2s_pkg::*;

    // One result bit per stage: floor(sqrt(radicand * 2^(2*FRAC_BITS))).
    logic [ROOT_BITS-1:0] root_reg [1:ROOT_BITS];
    logic [REM_BITS-1:0]  rem_reg  [1:ROOT_BITS-1];
    logic [SQ_BITS-1:0]   sq_reg   [1:ROOT_BITS-1];

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_digit
        logic [SQ_BITS-1:0]   sq_cur;
        logic [REM_BITS-1:0]  rem_cur;
        logic [REM_BITS-1:0]  rem_shl;
        logic [REM_BITS-1:0]  trial;
        logic [ROOT_BITS-1:0] root_cur;
        logic                 fits;

        if (j == 0)
        begin : g_first
            assign sq_cur   = radicand;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end
        else
        begin : g_rest
            assign sq_cur   = sq_reg[j];
            assign rem_cur  = rem_reg[j];
            assign root_cur = root_reg[j];
        end

        // Remainder stays below 2^(REM_BITS-2), so two top bits shifted out are zero.
        assign rem_shl = {rem_cur[REM_BITS-3:0], sq_cur[SQ_BITS-1 -: 2]};
        assign trial   = {1'b0, root_cur, 2'b01};
        assign fits    = (rem_shl >= trial);

        always_ff @(posedge clk)
        begin
            root_reg[j+1] <= {root_cur[ROOT_BITS-2:0], fits};
        end

        if (j < ROOT_BITS - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                rem_reg[j+1] <= fits ? (rem_shl - trial) : rem_shl;
                sq_reg[j+1]  <= {sq_cur[SQ_BITS-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_BITS];

endmodule

FILE: src/c2s_cordic.sv
module c2s_cordic (
    input  logic                                clk,
    input  logic signed [c2s_pkg::CW-1:0]       x_in,
    input  logic signed [c2s_pkg::CW-1:0]       y_in,
    input  logic        [c2s_pkg::ACC_BITS-1:0] ang_in,
    output logic        [c2s_pkg::ACC_BITS-1:0] ang_out
);
    import c2s_pkg::*;

    // Vectoring mode: each stage drives y toward zero and sums its rotation angle.
    logic signed [CW-1:0]       x_reg   [1:NSTEPS-1];
    logic signed [CW-1:0]       y_reg   [1:NSTEPS-1];
    logic        [ACC_BITS-1:0] ang_reg [1:NSTEPS];

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_step
        logic signed [CW-1:0]       y_cur;
        logic        [ACC_BITS-1:0] ang_cur;

        if (i == 0)
        begin : g_first
            assign y_cur   = y_in;
            assign ang_cur = ang_in;
        end
        else
        begin : g_rest
            assign y_cur   = y_reg[i];
            assign ang_cur = ang_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (y_cur[CW-1])
            begin
                ang_reg[i+1] <= ang_cur - ATAN_TAB[i];
            end
            else
            begin
                ang_reg[i+1] <= ang_cur + ATAN_TAB[i];
            end
        end

        // Final stage only needs y's sign, so x and y stop one stage early.
        if (i < NSTEPS - 1)
        begin : g_rot
            logic signed [CW-1:0] x_cur;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            if (i == 0)
            begin : g_x0
                assign x_cur = x_in;
            end
            else
            begin : g_xn
                assign x_cur = x_reg[i];
            end

            assign dx = y_cur >>> i;
            assign dy = x_cur >>> i;

            always_ff @(posedge clk)
            begin
                if (y_cur[CW-1])
                begin
                    x_reg[i+1] <= x_cur - dx;
                    y_reg[i+1] <= y_cur + dy;
                end
                else
                begin
                    x_reg[i+1] <= x_cur + dx;
                    y_reg[i+1] <= y_cur - dy;
                end
            end
        end
    end

    assign ang_out = ang_reg[NSTEPS];

endmodule

FILE: src/cartesian_to_spherical_unit.sv
// Converts a 3-D point (x_coord, y_coord, z_coord) into azimuth, elevation and
// radius. Angles are 20-bit binary angles where 2^19 stands for pi; an azimuth of
// +pi reads as -2^19, azimuth is zero when x and y are both zero, and elevation is
// zero for a zero vector. Radius is Euclidean length at input scale, rounded half
// up. A request is taken on any clock edge where start is high and busy is low;
// busy is high only during reset and until the first clock edge after it, so a
// new point may enter on every cycle. Each result appears for exactly one clock
// with done high, and results leave in request order. The path runs through a
// 40-stage digit-by-digit square root feeding a 20-stage CORDIC for elevation,
// plus input, multiply, sum and output registers. Results cannot be held off:
// whoever listens must take each one in its done cycle.
module cartesian_to_spherical_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]  x_coord,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]  y_coord,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]  z_coord,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [c2s_pkg::ANGLE_BITS-1:0]  azimuth,
    output logic signed [c2s_pkg::ANGLE_BITS-1:0]  elevation,
    output logic        [c2s_pkg::COORD_BITS-1:0]  radius
);
    import c2s_pkg::*;

    // Stage numbering counts clock edges after a request is taken.
    localparam int TP      = ROOT_BITS + 3;   // square roots ready
    localparam int AZ_CORE = NSTEPS + 2;      // azimuth CORDIC angle ready
    localparam int XT      = CW - FRAC_BITS;  // width of a coordinate before scaling

    localparam logic [ACC_BITS-1:0] ACC_PI    = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [ACC_BITS-1:0] ACC_ZERO  = '0;
    localparam logic [ACC_BITS-1:0] ROUND_ADD =
        ACC_BITS'(1) << (ACC_BITS - ANGLE_BITS - 1);

    localparam logic signed [ANGLE_BITS-1:0] ANG_ZERO  = '0;
    localparam logic signed [ANGLE_BITS-1:0] ANG_PI    =
        {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS-1:0] ANG_HALF  =
        {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [ANGLE_BITS-1:0] ANG_NHALF =
        {2'b11, {(ANGLE_BITS-2){1'b0}}};

    localparam logic [ROOT_BITS:0] RAD_ROUND = (ROOT_BITS+1)'(1) << (FRAC_BITS - 1);

    // Round a 32-bit binary angle to output precision; overflow wraps +pi to -pi.
    function automatic logic signed [ANGLE_BITS-1:0] round_angle(
        input logic [ACC_BITS-1:0] a
    );
        logic [ACC_BITS-1:0] s;
        s = a + ROUND_ADD;
        return s[ACC_BITS-1 -: ANGLE_BITS];
    endfunction

    // Handshake. No backpressure exists inside, so only reset makes us busy.
    logic             rdy_reg;
    logic             accept;
    logic [LATENCY:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_reg <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            rdy_reg <= 1'b1;
            vld_reg <= {vld_reg[LATENCY-1:1], accept};
        end
    end

    assign accept = start & rdy_reg;
    assign busy   = ~rdy_reg;
    assign done   = vld_reg[LATENCY];

    // Stage 1: capture request.
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [COORD_BITS-1:0] z1_reg;

    always_ff @(posedge clk)
    begin
        x1_reg <= x_coord;
        y1_reg <= y_coord;
        z1_reg <= z_coord;
    end

    // Stage 2: squares, azimuth CORDIC operands, and axis cases.
    // When x is negative, vector is flipped into right half plane and
    // azimuth starts from pi. Points on an axis bypass CORDIC entirely.
    logic signed [SQ_BITS-1:0]    xsq;
    logic signed [SQ_BITS-1:0]    ysq;
    logic signed [SQ_BITS-1:0]    zsq;
    logic signed [XT-1:0]         xe;
    logic signed [XT-1:0]         ye;
    logic                         x_zero;
    logic                         y_zero;
    logic                         z_zero;
    logic signed [ANGLE_BITS-1:0] azfix_next;
    logic                         azfen_next;
    logic signed [ANGLE_BITS-1:0] elfix_next;
    logic                         elfen_next;

    assign xsq    = x1_reg * x1_reg;
    assign ysq    = y1_reg * y1_reg;
    assign zsq    = z1_reg * z1_reg;
    assign xe     = {{(XT-COORD_BITS){x1_reg[COORD_BITS-1]}}, x1_reg};
    assign ye     = {{(XT-COORD_BITS){y1_reg[COORD_BITS-1]}}, y1_reg};
    assign x_zero = (x1_reg == '0);
    assign y_zero = (y1_reg == '0);
    assign z_zero = (z1_reg == '0);

    always_comb
    begin
        azfix_next = ANG_ZERO;
        azfen_next = 1'b0;
        if (x_zero && y_zero)
        begin
            azfen_next = 1'b1;
        end
        else if (y_zero)
        begin
            azfen_next = 1'b1;
            azfix_next = x1_reg[COORD_BITS-1] ? ANG_PI : ANG_ZERO;
        end
        else if (x_zero)
        begin
            azfen_next = 1'b1;
            azfix_next = y1_reg[COORD_BITS-1] ? ANG_NHALF : ANG_HALF;
        end

        elfix_next = ANG_ZERO;
        elfen_next = 1'b0;
        if (z_zero)
        begin
            elfen_next = 1'b1;
        end
        else if (x_zero && y_zero)
        begin
            elfen_next = 1'b1;
            elfix_next = z1_reg[COORD_BITS-1] ? ANG_NHALF : ANG_HALF;
        end
    end

    logic        [SQ_BITS-1:0]    xx_reg;
    logic        [SQ_BITS-1:0]    yy_reg;
    logic        [SQ_BITS-1:0]    zz_reg;
    logic signed [CW-1:0]         ax_reg;
    logic signed [CW-1:0]         ay_reg;
    logic        [ACC_BITS-1:0]   a0_reg;
    logic signed [ANGLE_BITS-1:0] azfix_reg [2:AZ_CORE];
    logic                         azfen_reg [2:AZ_CORE];
    logic signed [ANGLE_BITS-1:0] elfix_reg [2:LATENCY-1];
    logic                         elfen_reg [2:LATENCY-1];
    logic signed [COORD_BITS-1:0] zd_reg    [2:TP];

    always_ff @(posedge clk)
    begin
        xx_reg <= $unsigned(xsq);
        yy_reg <= $unsigned(ysq);
        zz_reg <= $unsigned(zsq);
        if (x1_reg[COORD_BITS-1])
        begin
            ax_reg <= {-xe, {FRAC_BITS{1'b0}}};
            ay_reg <= {-ye, {FRAC_BITS{1'b0}}};
            a0_reg <= ACC_PI;
        end
        else
        begin
            ax_reg <= {xe, {FRAC_BITS{1'b0}}};
            ay_reg <= {ye, {FRAC_BITS{1'b0}}};
            a0_reg <= ACC_ZERO;
        end
        azfix_reg[2] <= azfix_next;
        azfen_reg[2] <= azfen_next;
        elfix_reg[2] <= elfix_next;
        elfen_reg[2] <= elfen_next;
        zd_reg[2]    <= z1_reg;
        for (int k = 3; k <= AZ_CORE; k++)
        begin
            azfix_reg[k] <= azfix_reg[k-1];
            azfen_reg[k] <= azfen_reg[k-1];
        end
        for (int k = 3; k <= LATENCY - 1; k++)
        begin
            elfix_reg[k] <= elfix_reg[k-1];
            elfen_reg[k] <= elfen_reg[k-1];
        end
        for (int k = 3; k <= TP; k++)
        begin
            zd_reg[k] <= zd_reg[k-1];
        end
    end

    // Stage 3: planar and full sums of squares.
    logic [SQ_BITS-1:0] sxy_reg;
    logic [SQ_BITS-1:0] sxyz_reg;

    always_ff @(posedge clk)
    begin
        sxy_reg  <= xx_reg + yy_reg;
        sxyz_reg <= xx_reg + yy_reg + zz_reg;
    end

    // Two square roots run side by side, both scaled by 2^FRAC_BITS:
    // planar length feeds elevation CORDIC, full length gives radius.
    logic [ROOT_BITS-1:0] root_p;
    logic [ROOT_BITS-1:0] root_r;

    c2s_isqrt u_sqrt_plane (
        .clk      (clk),
        .radicand (sxy_reg),
        .root     (root_p)
    );

    c2s_isqrt u_sqrt_full (
        .clk      (clk),
        .radicand (sxyz_reg),
        .root     (root_r)
    );

    // Azimuth CORDIC starts right after stage 2; its rounded result then
    // waits in a delay line for elevation to catch up.
    logic [ACC_BITS-1:0]          az_ang;
    logic signed [ANGLE_BITS-1:0] az_dly [AZ_CORE+1:LATENCY-1];

    c2s_cordic u_cordic_az (
        .clk     (clk),
        .x_in    (ax_reg),
        .y_in    (ay_reg),
        .ang_in  (a0_reg),
        .ang_out (az_ang)
    );

    always_ff @(posedge clk)
    begin
        az_dly[AZ_CORE+1] <= azfen_reg[AZ_CORE] ? azfix_reg[AZ_CORE] : round_angle(az_ang);
        for (int k = AZ_CORE + 2; k <= LATENCY - 1; k++)
        begin
            az_dly[k] <= az_dly[k-1];
        end
    end

    // Radius: full root carries 16 fraction bits; round half up to an integer.
    logic [ROOT_BITS:0]    rad_sum;
    logic [COORD_BITS-1:0] rad_dly [TP+1:LATENCY-1];

    assign rad_sum = {1'b0, root_r} + RAD_ROUND;

    always_ff @(posedge clk)
    begin
        rad_dly[TP+1] <= rad_sum[FRAC_BITS +: COORD_BITS];
        for (int k = TP + 2; k <= LATENCY - 1; k++)
        begin
            rad_dly[k] <= rad_dly[k-1];
        end
    end

    // Elevation CORDIC on (planar length, z), both scaled by 2^FRAC_BITS.
    logic signed [CW-1:0]         el_x;
    logic signed [CW-1:0]         el_y;
    logic [ACC_BITS-1:0]          el_ang;
    logic signed [ANGLE_BITS-1:0] el_round;
    logic signed [ANGLE_BITS-1:0] el_clamp;

    assign el_x = {{(CW-ROOT_BITS){1'b0}}, root_p};
    assign el_y = {{(XT-COORD_BITS){zd_reg[TP][COORD_BITS-1]}}, zd_reg[TP],
                   {FRAC_BITS{1'b0}}};

    c2s_cordic u_cordic_el (
        .clk     (clk),
        .x_in    (el_x),
        .y_in    (el_y),
        .ang_in  (ACC_ZERO),
        .ang_out (el_ang)
    );

    // CORDIC residue can overshoot a quarter turn by a few counts; clamp it.
    always_comb
    begin
        el_round = round_angle(el_ang);
        if (el_round > ANG_HALF)
        begin
            el_clamp = ANG_HALF;
        end
        else if (el_round < ANG_NHALF)
        begin
            el_clamp = ANG_NHALF;
        end
        else
        begin
            el_clamp = el_round;
        end
    end

    // Output registers, shown for one clock under done.
    logic signed [ANGLE_BITS-1:0] azimuth_reg;
    logic signed [ANGLE_BITS-1:0] elevation_reg;
    logic        [COORD_BITS-1:0] radius_reg;

    always_ff @(posedge clk)
    begin
        azimuth_reg   <= az_dly[LATENCY-1];
        elevation_reg <= elfen_reg[LATENCY-1] ? elfix_reg[LATENCY-1] : el_clamp;
        radius_reg    <= rad_dly[LATENCY-1];
    end

    assign azimuth   = azimuth_reg;
    assign elevation = elevation_reg;
    assign radius    = radius_reg;

endmodule

FILE: src/c2s_checker.sv
module c2s_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic signed [c2s_pkg::COORD_BITS-1:0]  x_coord,
    input logic signed [c2s_pkg::COORD_BITS-1:0]  y_coord,
    input logic signed [c2s_pkg::COORD_BITS-1:0]  z_coord,
    input logic                                   busy,
    input logic                                   done,
    input logic signed [c2s_pkg::ANGLE_BITS-1:0]  azimuth,
    input logic signed [c2s_pkg::ANGLE_BITS-1:0]  elevation,
    input logic        [c2s_pkg::COORD_BITS-1:0]  radius
);
    import c2s_pkg::*;

    localparam logic signed [ANGLE_BITS-1:0] EL_MAX =
        {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [ANGLE_BITS-1:0] EL_MIN =
        {2'b11, {(ANGLE_BITS-2){1'b0}}};

    // Every taken request yields a strobe after a fixed latency.
    a_done_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done
    ) else $error("request taken but no result after fixed latency");

    // No strobe without a matching request.
    a_no_spurious: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY)
    ) else $error("result strobe without a matching request");

    // Elevation never leaves a quarter turn either way.
    a_elev_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (elevation <= EL_MAX && elevation >= EL_MIN)
    ) else $error("elevation outside quarter-turn range");

    // A point on z axis has zero azimuth and radius equal to |z|.
    a_z_axis: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(x_coord == '0 && y_coord == '0, LATENCY)) |->
        (azimuth == '0 &&
         radius == $past(z_coord[COORD_BITS-1] ? COORD_BITS'(-z_coord)
                                               : COORD_BITS'(z_coord), LATENCY))
    ) else $error("point on z axis gave wrong azimuth or radius");

endmodule

bind cartesian_to_spherical_unit c2s_checker u_c2s_checker (.*);

FILE: sim/spherical_checker.sv
`timescale 1ns / 1ps

module spherical_checker
    import c2s_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    input  logic signed [COORD_BITS-1:0] z_coord,
    input  logic                         done,
    input  logic signed [ANGLE_BITS-1:0] azimuth,
    input  logic signed [ANGLE_BITS-1:0] elevation,
    input  logic        [COORD_BITS-1:0] radius,
    output int                           failures,
    output int                           outstanding
);

    localparam longint SCALE = longint'(1) << FRAC_BITS;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam longint EL_LIMIT = longint'(1) << (ANGLE_BITS - 2);
    localparam logic [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) << (ACC_BITS - ANGLE_BITS - 1);
    localparam logic [ACC_BITS-1:0] PI_ACC     = ACC_BITS'(1) << (ACC_BITS - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic signed [ANGLE_BITS-1:0] az;
        logic signed [ANGLE_BITS-1:0] el;
        logic        [COORD_BITS-1:0] rad;
    } point_result_t;

    point_result_t pending_points[$];
    int            reported;

    // floor(sqrt(s) * 2^f), one result bit per pair of input bits.
    function automatic longint unsigned root_scaled(input longint unsigned s, input int f);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned pair;
        longint unsigned trial;
        int              k;
        root = 0;
        rem  = 0;
        for (k = 31; k >= -f; k--)
        begin
            pair  = (k >= 0) ? ((s >> (2 * k)) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Vectoring CORDIC: drives the vector onto the x axis and returns the
    // accumulated angle.
    function automatic logic [ACC_BITS-1:0] cordic_angle(input longint cx, input longint cy,
                                                         input logic [ACC_BITS-1:0] ang0);
        longint               dx;
        longint               dy;
        logic [ACC_BITS-1:0]  ang;
        int                   i;
        ang = ang0;
        for (i = 0; i < NSTEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy < 0)
            begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - ATAN_TAB[i];
            end
            else
            begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + ATAN_TAB[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [ACC_BITS-1:0] a);
        logic [ACC_BITS-1:0] t;
        t = a + ROUND_HALF;
        return ANGLE_BITS'(t >> (ACC_BITS - ANGLE_BITS));
    endfunction

    function automatic point_result_t to_spherical(input logic signed [COORD_BITS-1:0] x,
                                                   input logic signed [COORD_BITS-1:0] y,
                                                   input logic signed [COORD_BITS-1:0] z);
        longint               sx;
        longint               sy;
        longint               sz;
        longint unsigned      sxy;
        longint unsigned      sxyz;
        longint unsigned      planar;
        longint               es;
        logic [ANGLE_BITS-1:0] e;
        point_result_t        r;
        sx   = x;
        sy   = y;
        sz   = z;
        sxy  = sx * sx + sy * sy;
        sxyz = sxy + sz * sz;
        r.x  = x;
        r.y  = y;
        r.z  = z;

        if (sx == 0 && sy == 0)
            r.az = '0;
        else if (sy == 0)
            r.az = (sx > 0) ? '0 : HALF_TURN;
        else if (sx == 0)
            r.az = (sy > 0) ? QUARTER_TURN : -QUARTER_TURN;
        else if (sx < 0)
            r.az = round_angle(cordic_angle(-sx * SCALE, -sy * SCALE, PI_ACC));
        else
            r.az = round_angle(cordic_angle(sx * SCALE, sy * SCALE, '0));

        if (sz == 0)
            r.el = '0;
        else if (sxy == 0)
            r.el = (sz > 0) ? QUARTER_TURN : -QUARTER_TURN;
        else
        begin
            planar = root_scaled(sxy, FRAC_BITS);
            e  = round_angle(cordic_angle(longint'(planar), sz * SCALE, '0));
            es = longint'($signed(e));
            if (es > EL_LIMIT)
                es = EL_LIMIT;
            if (es < -EL_LIMIT)
                es = -EL_LIMIT;
            r.el = ANGLE_BITS'(es);
        end

        r.rad = COORD_BITS'((root_scaled(sxyz, 1) + 64'd1) >> 1);
        return r;
    endfunction

    always @(posedge clk)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            failures    <= 0;
            outstanding <= 0;
            reported     = 0;
        end
        else
        begin
            // A result never leaves at the edge that takes its request, so the
            // oldest expectation is retired before this edge's request joins.
            if (done)
            begin
                if (pending_points.size() == 0)
                begin
                    failures <= failures + 1;
                    if (reported < 10)
                        $display("unexpected result: az=%0d el=%0d r=%0d",
                                 azimuth, elevation, radius);
                    reported++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (azimuth !== want.az || elevation !== want.el || radius !== want.rad)
                    begin
                        failures <= failures + 1;
                        if (reported < 10)
                            $display({"mismatch for (%0d,%0d,%0d): expected az=%0d el=%0d ",
                                      "r=%0d, got az=%0d el=%0d r=%0d"},
                                     want.x, want.y, want.z, want.az, want.el, want.rad,
                                     azimuth, elevation, radius);
                        reported++;
                    end
                end
            end
            if (start && !busy)
                pending_points.push_back(to_spherical(x_coord, y_coord, z_coord));
            outstanding <= pending_points.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

// Top of the testbench for the Cartesian-to-spherical converter. This module
// only produces requests and gives the verdict; the spherical_checker beside
// the block watches both sides, predicts every result and counts failures.
module tb;

    typedef logic signed [c2s_pkg::COORD_BITS-1:0] coord_t;

    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     RANDOM_POINTS = 800;
    // Past this many random requests the sender stops idling.
    localparam int     CALM_AFTER    = 650;
    localparam coord_t C_MAX         = 24'sh7FFFFF;
    localparam coord_t C_MIN         = -24'sh800000;

    // Directed points: the zero vector, each axis, the extremes, azimuths
    // next to pi, tall points whose elevation saturates, and a few ordinary
    // points.
    localparam int N_DIRECTED = 24;
    localparam int DIRECTED [N_DIRECTED][3] = '{
        '{0, 0, 0},
        '{5, 0, 0},
        '{-5, 0, 0},
        '{0, 7, 0},
        '{0, -7, 0},
        '{0, 0, 9},
        '{0, 0, -9},
        '{0, 0, -8388608},
        '{8388607, 8388607, 8388607},
        '{-8388608, -8388608, -8388608},
        '{-8388608, 0, 0},
        '{8388607, -8388608, 8388607},
        '{-8388608, 8388607, -8388608},
        '{-8388608, 1, 0},
        '{-8388608, -1, 0},
        '{-8388607, 1, 3},
        '{1, 0, 8388607},
        '{0, 1, -8388608},
        '{-1, -1, 8388607},
        '{1, 1, 1},
        '{-1, 1, -1},
        '{3, -4, 12},
        '{-1, -1, -1},
        '{8388607, 0, -1}
    };

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
    logic   busy;
    logic   done;
    logic signed [c2s_pkg::ANGLE_BITS-1:0] azimuth;
    logic signed [c2s_pkg::ANGLE_BITS-1:0] elevation;
    logic        [c2s_pkg::COORD_BITS-1:0] radius;
    int     failures;
    int     outstanding;
    int     cycles = 0;

    // 2 ns clock: one time unit high, one low.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cartesian_to_spherical_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_coord   (z_coord),
        .busy      (busy),
        .done      (done),
        .azimuth   (azimuth),
        .elevation (elevation),
        .radius    (radius)
    );

    spherical_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .z_coord     (z_coord),
        .done        (done),
        .azimuth     (azimuth),
        .elevation   (elevation),
        .radius      (radius),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Watchdog. A correct run finishes well within this limit, even
    // with every request behind the longest idle burst.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Presents one request and holds it until an edge where busy is low
    // takes it. Busy is read right after the edge, so it still shows the
    // value the block saw at that edge.
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
        start   <= 1'b1;
        x_coord <= px;
        y_coord <= py;
        z_coord <= pz;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap. The coordinate ports carry noise meanwhile, which the
    // block must ignore while start is low.
    task automatic hold_off(input int n);
        start   <= 1'b0;
        x_coord <= coord_t'($urandom());
        y_coord <= coord_t'($urandom());
        z_coord <= coord_t'($urandom());
        repeat (n) @(posedge clk);
    endtask

    // Stops sending and waits for every predicted result to come back. The
    // first edge is always waited so the checker has counted the last
    // request before the count is trusted.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // A random coordinate: mostly full-range words so that every bit
    // toggles, with zeros, small magnitudes and extremes mixed in so that
    // axis-aligned and near-axis points come up often.
    function automatic coord_t pick_coord();
        coord_t c;
        case ($urandom_range(0, 9))
            0:       c = '0;
            1, 2:
            begin
                c = coord_t'($urandom_range(1, 300));
                if ($urandom_range(0, 1) == 1)
                    c = -c;
            end
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       c = C_MAX;
                    1:       c = C_MIN;
                    2:       c = 24'sd1;
                    default: c = -24'sd1;
                endcase
            end
            default: c = coord_t'($urandom());
        endcase
        return c;
    endfunction

    initial
    begin
        start   <= 1'b0;
        x_coord <= '0;
        y_coord <= '0;
        z_coord <= '0;
        rst_n   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n   <= 1'b1;

        // Directed points, back to back.
        for (int i = 0; i < N_DIRECTED; i++)
            send_point(coord_t'(DIRECTED[i][0]), coord_t'(DIRECTED[i][1]),
                       coord_t'(DIRECTED[i][2]));
        drain_results();

        // Random points. Idle bursts land at random places in the pipeline;
        // halfway through, the sender waits until the block has emptied, and
        // the last stretch runs at full rate.
        for (int i = 0; i < RANDOM_POINTS; i++)
        begin
            if (i == RANDOM_POINTS / 2)
                drain_results();
            else if (i < CALM_AFTER && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 18));
            send_point(pick_coord(), pick_coord(), pick_coord());
        end

        drain_results();
        // Any result that trails in after this point is flagged by the checker.
        repeat (c2s_pkg::LATENCY + 8) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
